/* src/alls_pkg.sv */
// ----------------------------------------------------------------------------
// alls_pkg
// Shared types and constants for the access log line splitter.
// ----------------------------------------------------------------------------
package alls_pkg;

  // field codes, in the order the fields appear on a line
  localparam logic [3:0] FLD_IP       = 4'd0;
  localparam logic [3:0] FLD_IDENTD   = 4'd1;
  localparam logic [3:0] FLD_USER     = 4'd2;
  localparam logic [3:0] FLD_TIME     = 4'd3;
  localparam logic [3:0] FLD_REQUEST  = 4'd4;
  localparam logic [3:0] FLD_STATUS   = 4'd5;
  localparam logic [3:0] FLD_SIZE     = 4'd6;
  localparam logic [3:0] FLD_REFERER  = 4'd7;
  localparam logic [3:0] FLD_AGENT    = 4'd8;

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_QUOTE   = 8'h22;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_ONE     = 8'h31;

  localparam int         TIME_LEN     = 28;
  localparam int         TIME_OUT     = 20;
  localparam logic [4:0] TIME_LAST_IN = 5'(TIME_LEN - 1);
  localparam logic [4:0] TIME_LAST_OUT = 5'(TIME_OUT - 1);
  localparam logic [4:0] TIME_MON_HI  = 5'd4;
  localparam logic [4:0] TIME_MON_LO  = 5'd5;
  localparam logic [4:0] TIME_GAP     = 5'd14;

  typedef enum logic [2:0] {
    S_ACCEPT = 3'b001,
    S_TIME   = 3'b010,
    S_TAIL   = 3'b100
  } ctrl_state_t;

  typedef struct packed {
    logic       take;       // input transfer this cycle
    logic       load_time;  // load time result number time_idx
    logic       load_tail;  // load the close result that follows a data byte
    logic [4:0] time_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;  // output register can take a result this cycle
    logic time_done;  // offered byte completes the time field
    logic need_tail;  // offered byte is data and ends the line
  } dp_sts_t;

  // buffer position of each time output character (month and gap are built)
  function automatic logic [4:0] time_pick(input logic [4:0] idx);
    logic [4:0] p;
    case (idx)
      5'd0:    p = 5'd8;
      5'd1:    p = 5'd9;
      5'd2:    p = 5'd10;
      5'd3:    p = 5'd11;
      5'd6:    p = 5'd1;
      5'd7:    p = 5'd2;
      5'd8:    p = 5'd13;
      5'd9:    p = 5'd14;
      5'd10:   p = 5'd16;
      5'd11:   p = 5'd17;
      5'd12:   p = 5'd19;
      5'd13:   p = 5'd20;
      5'd15:   p = 5'd22;
      5'd16:   p = 5'd23;
      5'd17:   p = 5'd24;
      5'd18:   p = 5'd25;
      5'd19:   p = 5'd26;
      default: p = 5'd0;
    endcase
    return p;
  endfunction

endpackage

/* src/access_log_line_splitter.sv */
// ----------------------------------------------------------------------------
// access_log_line_splitter
// Splits an access log line, one byte per transfer, into its nine fields.
// ----------------------------------------------------------------------------
//  channel | dir | tdata          | tuser                          | tlast
//  in_     | in  | [7:0] in_byte  | -                              | line_end
//  out_    | out | [7:0] out_byte | [3:0] field_index, [4] byte_valid,
//          |     |                | [5] field_end, [6] month_bad,
//          |     |                | [7] run_last                   | line_done
//
//  ordinary bytes: one transfer per cycle in and out while out_tready is high, registered
//  the byte that completes the time field gives 20 results, one per cycle while
//  out_tready is high, from the single output register; input waits until all are sent
//  a data byte that ends the line gives two results: the byte, then a close result
//  reset clears field tracking and output valid; payload and time buffer are not reset
//  out_tready low holds the output register and, through it, in_tready
module access_log_line_splitter
  import alls_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [7:0] out_tuser,  // [3:0] field_index, [4] byte_valid, [5] field_end,
                                 // [6] month_bad, [7] run_last
  output logic       out_tlast
);

  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic [3:0] o_field;
  logic       o_bvalid, o_fend, o_mbad, o_rlast;

  alls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  alls_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_field  (o_field),
    .out_byte   (out_tdata),
    .out_bvalid (o_bvalid),
    .out_fend   (o_fend),
    .out_mbad   (o_mbad),
    .out_ldone  (out_tlast),
    .out_rlast  (o_rlast)
  );

  assign out_tuser = {o_rlast, o_mbad, o_fend, o_bvalid, o_field};

`ifndef SYNTHESIS
  // no input transfer while the time burst is being sent
  a_no_take_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && cmd.load_time))
    else $error("input accepted during time burst");

  // line end is always the last result of its byte
  a_ldone_rlast: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[7])
    else $error("line_done without run_last");

  // month flag only on time results
  a_mbad_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[6] |-> out_tuser[3:0] == FLD_TIME)
    else $error("month_bad outside time field");

  // results without a character carry a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[4] |-> out_tdata == 8'd0)
    else $error("nonzero byte on non-character result");
`endif

endmodule

/* src/alls_ctrl.sv */
// ----------------------------------------------------------------------------
// alls_ctrl
// Sequencer: accepts bytes, steps through the 20 time results and the
// extra close result at line end.
// ----------------------------------------------------------------------------
module alls_ctrl
  import alls_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic        in_fire;

  assign in_tready = (state_r == S_ACCEPT) && sts.slot_free;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    cmd.take      = in_fire;
    cmd.load_time = (state_r == S_TIME) && sts.slot_free;
    cmd.load_tail = (state_r == S_TAIL) && sts.slot_free;
    cmd.time_idx  = idx_r;
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_ACCEPT: begin
        idx_nxt = 5'd0;
        if (in_fire && sts.time_done) begin
          state_nxt = S_TIME;
        end else if (in_fire && sts.need_tail) begin
          state_nxt = S_TAIL;
        end
      end
      S_TIME: begin
        if (sts.slot_free) begin
          if (idx_r == TIME_LAST_OUT) begin
            state_nxt = S_ACCEPT;
            idx_nxt   = 5'd0;
          end else begin
            idx_nxt = idx_r + 5'd1;
          end
        end
      end
      S_TAIL: begin
        if (sts.slot_free) begin
          state_nxt = S_ACCEPT;
        end
      end
      default: begin
        state_nxt = S_ACCEPT;
        idx_nxt   = 5'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACCEPT;
      idx_r   <= 5'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

/* src/alls_dpath.sv */
// ----------------------------------------------------------------------------
// alls_dpath
// Field tracking, time buffer, month decode and the output register.
// ----------------------------------------------------------------------------
module alls_dpath
  import alls_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  dp_cmd_t    cmd,
  output dp_sts_t    sts,
  input  logic       out_tready,
  output logic       out_valid,
  output logic [3:0] out_field,
  output logic [7:0] out_byte,
  output logic       out_bvalid,
  output logic       out_fend,
  output logic       out_mbad,
  output logic       out_ldone,
  output logic       out_rlast
);

  logic [3:0] field_r, field_nxt, field_s;
  logic [1:0] skip_r, skip_nxt, skip_s;
  logic [4:0] tpos_r, tpos_nxt, tpos_s;
  logic       lover_r, lover_nxt, lover_s;
  logic [7:0] tbuf_r [TIME_LEN];
  logic       last_r;
  logic [3:0] pend_field_r;

  logic       out_valid_r;
  logic [3:0] out_field_r;
  logic [7:0] out_byte_r;
  logic       out_bvalid_r, out_fend_r, out_mbad_r, out_ldone_r, out_rlast_r;

  logic       blocked, skipping, in_time, ordinary, is_close, is_data;
  logic [7:0] ending;
  logic [4:0] wpos;
  logic       buf_we, time_done, prim_load, mark_close, load_any;

  function automatic logic [3:0] month_decode(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
    logic [3:0] m;
    case (a)
      "A":     m = (b == "p") ? 4'd4 : ((b == "u") ? 4'd8 : 4'd0);
      "D":     m = 4'd12;
      "F":     m = 4'd2;
      "J":     m = (b == "a") ? 4'd1 : ((c == "n") ? 4'd6 : ((c == "l") ? 4'd7 : 4'd0));
      "M":     m = (c == "r") ? 4'd3 : ((c == "y") ? 4'd5 : 4'd0);
      "N":     m = 4'd11;
      "O":     m = 4'd10;
      "S":     m = 4'd9;
      default: m = 4'd0;
    endcase
    return m;
  endfunction

  assign blocked  = lover_r || (field_r > FLD_AGENT);
  assign skipping = !blocked && (skip_r != 2'd0);
  assign in_time  = !blocked && !skipping && (field_r == FLD_TIME);
  assign ordinary = !blocked && !skipping && !in_time;
  assign ending   = ((field_r == FLD_REQUEST) || (field_r == FLD_REFERER) ||
                     (field_r == FLD_AGENT)) ? CHAR_QUOTE : CHAR_SPACE;
  assign is_close = ordinary && (in_byte == ending);
  assign is_data  = ordinary && !is_close;
  assign wpos     = (tpos_r >= 5'(TIME_LEN)) ? 5'd0 : tpos_r;
  assign time_done = in_time && (wpos == TIME_LAST_IN);

  // state after this byte, before the line end clears it
  always_comb begin
    field_s = field_r;
    skip_s  = skip_r;
    tpos_s  = tpos_r;
    lover_s = lover_r;
    buf_we  = 1'b0;
    if (blocked) begin
      lover_s = 1'b1;
    end else if (skipping) begin
      skip_s = skip_r - 2'd1;
    end else if (in_time) begin
      buf_we = 1'b1;
      if (time_done) begin
        tpos_s  = 5'd0;
        field_s = FLD_REQUEST;
        skip_s  = 2'd2;
      end else begin
        tpos_s = wpos + 5'd1;
      end
    end else if (is_close) begin
      case (field_r)
        FLD_IP:      field_s = FLD_IDENTD;
        FLD_IDENTD:  field_s = FLD_USER;
        FLD_USER: begin
          field_s = FLD_TIME;
          tpos_s  = 5'd0;
        end
        FLD_REQUEST: begin
          field_s = FLD_STATUS;
          skip_s  = 2'd1;
        end
        FLD_STATUS:  field_s = FLD_SIZE;
        FLD_SIZE: begin
          field_s = FLD_REFERER;
          skip_s  = 2'd1;
        end
        FLD_REFERER: begin
          field_s = FLD_AGENT;
          skip_s  = 2'd2;
        end
        default:     lover_s = 1'b1;
      endcase
    end
  end

  // line end with no result of its own: close an open field, else a marker
  assign mark_close = !lover_s && (skip_s == 2'd0) && (field_s != FLD_TIME) &&
                      (field_s <= FLD_AGENT);
  assign prim_load  = is_data || is_close || (in_last && !time_done);

  always_comb begin
    if (in_last) begin
      field_nxt = FLD_IP;
      skip_nxt  = 2'd0;
      tpos_nxt  = 5'd0;
      lover_nxt = 1'b0;
    end else begin
      field_nxt = field_s;
      skip_nxt  = skip_s;
      tpos_nxt  = tpos_s;
      lover_nxt = lover_s;
    end
  end

  always_comb begin
    sts.slot_free = !out_valid_r || out_tready;
    sts.time_done = time_done;
    sts.need_tail = is_data && in_last;
  end

  // time result character
  logic [3:0] month;
  logic [3:0] month_lo;
  logic [7:0] time_ch;

  assign month    = month_decode(tbuf_r[4], tbuf_r[5], tbuf_r[6]);
  assign month_lo = (month >= 4'd10) ? (month - 4'd10) : month;

  always_comb begin
    case (cmd.time_idx)
      TIME_MON_HI: time_ch = (month < 4'd10) ? CHAR_ZERO : CHAR_ONE;
      TIME_MON_LO: time_ch = CHAR_ZERO + {4'd0, month_lo};
      TIME_GAP:    time_ch = CHAR_SPACE;
      default:     time_ch = tbuf_r[time_pick(cmd.time_idx)];
    endcase
  end

  assign load_any = (cmd.take && prim_load) || cmd.load_time || cmd.load_tail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r     <= FLD_IP;
      skip_r      <= 2'd0;
      tpos_r      <= 5'd0;
      lover_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.take) begin
        field_r <= field_nxt;
        skip_r  <= skip_nxt;
        tpos_r  <= tpos_nxt;
        lover_r <= lover_nxt;
      end
      if (load_any) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && buf_we) begin
      tbuf_r[wpos] <= in_byte;
    end
    if (cmd.take) begin
      last_r       <= in_last;
      pend_field_r <= field_r;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.load_time) begin
      out_field_r  <= FLD_TIME;
      out_byte_r   <= time_ch;
      out_bvalid_r <= 1'b1;
      out_fend_r   <= (cmd.time_idx == TIME_LAST_OUT);
      out_mbad_r   <= (month == 4'd0);
      out_ldone_r  <= (cmd.time_idx == TIME_LAST_OUT) && last_r;
      out_rlast_r  <= (cmd.time_idx == TIME_LAST_OUT);
    end else if (cmd.load_tail) begin
      out_field_r  <= pend_field_r;
      out_byte_r   <= 8'd0;
      out_bvalid_r <= 1'b0;
      out_fend_r   <= 1'b1;
      out_mbad_r   <= 1'b0;
      out_ldone_r  <= 1'b1;
      out_rlast_r  <= 1'b1;
    end else if (cmd.take && prim_load) begin
      out_mbad_r <= 1'b0;
      if (is_data) begin
        out_field_r  <= field_r;
        out_byte_r   <= in_byte;
        out_bvalid_r <= 1'b1;
        out_fend_r   <= 1'b0;
        out_ldone_r  <= 1'b0;
        out_rlast_r  <= !in_last;
      end else if (is_close) begin
        out_field_r  <= field_r;
        out_byte_r   <= 8'd0;
        out_bvalid_r <= 1'b0;
        out_fend_r   <= 1'b1;
        out_ldone_r  <= in_last;
        out_rlast_r  <= 1'b1;
      end else begin
        out_field_r  <= field_s;
        out_byte_r   <= 8'd0;
        out_bvalid_r <= 1'b0;
        out_fend_r   <= mark_close;
        out_ldone_r  <= 1'b1;
        out_rlast_r  <= 1'b1;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_field  = out_field_r;
  assign out_byte   = out_byte_r;
  assign out_bvalid = out_bvalid_r;
  assign out_fend   = out_fend_r;
  assign out_mbad   = out_mbad_r;
  assign out_ldone  = out_ldone_r;
  assign out_rlast  = out_rlast_r;

endmodule
